// ===== src/lbmc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbmc_pkg: shared types and constants of the D2Q9 collision core
// Fixed-point formats, beat structs, lattice tables and the saturate helper.
// ----------------------------------------------------------------------------
package lbmc_pkg;

  localparam int DW       = 24;          // data word, signed Q3.20
  localparam int FB       = 20;          // fraction bits of a data word
  localparam int NDIR     = 9;           // lattice directions
  localparam int OMEGA_W  = 17;          // omega, unsigned Q1.16
  localparam int OMEGA_FB = 16;

  localparam logic [OMEGA_W-1:0] OMEGA_RESET = OMEGA_W'(1 << OMEGA_FB);

  localparam int SUM_W  = DW + 4;        // sum of nine words
  localparam int MAG_W  = DW + 3;        // momentum magnitude
  localparam int SQ_W   = 2*DW - FB;     // (cu*cu) >> FB
  localparam int UU_W   = 2*DW + 1 - FB; // (ux^2 + uy^2) >> FB
  localparam int PS_W   = 2*DW - FB + 6; // polynomial before saturation
  localparam int P_W    = 2*DW - FB;     // floor(rho*poly >> FB)
  localparam int A_W    = P_W + 2;       // scaled magnitude fed to the /9 unit
  localparam int RECIP_SH = 32;
  localparam logic [RECIP_SH-1:0] RECIP9 = RECIP_SH'((64'd1 << RECIP_SH) / 64'd9);

  typedef logic signed [DW-1:0] sval_t;
  typedef sval_t [NDIR-1:0] dir_vec_t;

  localparam sval_t VAL_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam sval_t VAL_MIN = {1'b1, {(DW-1){1'b0}}};

  typedef enum logic [1:0] {
    WT_REST,
    WT_AXIS,
    WT_DIAG
  } wclass_t;

  localparam logic signed [1:0] DIR_X [NDIR] =
    '{2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd0, 2'sd1, -2'sd1, -2'sd1, 2'sd1};
  localparam logic signed [1:0] DIR_Y [NDIR] =
    '{2'sd0, 2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd1, 2'sd1, -2'sd1, -2'sd1};
  localparam int DIR_OPP [NDIR] = '{0, 3, 4, 1, 2, 7, 8, 5, 6};
  localparam wclass_t DIR_WT [NDIR] = '{WT_REST, WT_AXIS, WT_AXIS, WT_AXIS, WT_AXIS,
                                        WT_DIAG, WT_DIAG, WT_DIAG, WT_DIAG};

  typedef struct packed {
    logic  solid;
    sval_t dist_0;
    sval_t dist_1;
    sval_t dist_2;
    sval_t dist_3;
    sval_t dist_4;
    sval_t dist_5;
    sval_t dist_6;
    sval_t dist_7;
    sval_t dist_8;
  } node_beat_t;

  typedef struct packed {
    sval_t post_0;
    sval_t post_1;
    sval_t post_2;
    sval_t post_3;
    sval_t post_4;
    sval_t post_5;
    sval_t post_6;
    sval_t post_7;
    sval_t post_8;
    sval_t density;
    sval_t vel_x;
    sval_t vel_y;
  } result_beat_t;

  // Per-node context carried down the pipeline next to the arithmetic.
  typedef struct packed {
    logic     solid;
    sval_t    rho;
    sval_t    ux;
    sval_t    uy;
    dir_vec_t f;
  } ctx_t;

  // Moments handed to the velocity divider.
  typedef struct packed {
    ctx_t                  ctx;
    logic                  rho_pos;
    logic [1:0]            neg;
    logic [1:0][MAG_W-1:0] mag;
  } mom_t;

  function automatic sval_t sat(input logic signed [63:0] v);
    sval_t r;
    if (v > 64'(VAL_MAX)) begin
      r = VAL_MAX;
    end else if (v < 64'(VAL_MIN)) begin
      r = VAL_MIN;
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/lbmc_moments.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbmc_moments: density and momentum of one node
// Two stages: nine-way sums, then saturated density and momentum magnitudes.
// ----------------------------------------------------------------------------
module lbmc_moments (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  lbmc_pkg::node_beat_t node,
  output logic                out_valid,
  output lbmc_pkg::mom_t      mom
);

  localparam int SUM_W = lbmc_pkg::SUM_W;
  localparam int MAG_W = lbmc_pkg::MAG_W;
  localparam int NDIR  = lbmc_pkg::NDIR;

  logic                     s1_valid;
  logic                     s1_solid;
  lbmc_pkg::dir_vec_t       s1_f;
  logic signed [SUM_W-1:0]  s1_sum;
  logic signed [SUM_W-1:0]  s1_mx;
  logic signed [SUM_W-1:0]  s1_my;

  lbmc_pkg::dir_vec_t       f_c;
  logic signed [SUM_W-1:0]  sum_c;
  logic signed [SUM_W-1:0]  mx_c;
  logic signed [SUM_W-1:0]  my_c;

  always_comb begin
    logic signed [SUM_W-1:0] fe;
    f_c = {node.dist_8, node.dist_7, node.dist_6, node.dist_5, node.dist_4,
           node.dist_3, node.dist_2, node.dist_1, node.dist_0};
    sum_c = '0;
    mx_c  = '0;
    my_c  = '0;
    for (int k = 0; k < NDIR; k++) begin
      fe    = SUM_W'($signed(f_c[k]));
      sum_c = sum_c + fe;
      if (lbmc_pkg::DIR_X[k] == 2'sd1) begin
        mx_c = mx_c + fe;
      end else if (lbmc_pkg::DIR_X[k] == -2'sd1) begin
        mx_c = mx_c - fe;
      end
      if (lbmc_pkg::DIR_Y[k] == 2'sd1) begin
        my_c = my_c + fe;
      end else if (lbmc_pkg::DIR_Y[k] == -2'sd1) begin
        my_c = my_c - fe;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
    if (en) begin
      s1_solid <= node.solid;
      s1_f     <= f_c;
      s1_sum   <= sum_c;
      s1_mx    <= mx_c;
      s1_my    <= my_c;
    end
  end

  lbmc_pkg::mom_t mom_next;

  always_comb begin
    lbmc_pkg::sval_t rho;
    rho = lbmc_pkg::sat(64'(s1_sum));
    mom_next.ctx.solid = s1_solid;
    mom_next.ctx.rho   = rho;
    mom_next.ctx.ux    = '0;
    mom_next.ctx.uy    = '0;
    mom_next.ctx.f     = s1_f;
    mom_next.rho_pos   = !rho[lbmc_pkg::DW-1] && (rho != '0);
    mom_next.neg[0]    = s1_mx[SUM_W-1];
    mom_next.neg[1]    = s1_my[SUM_W-1];
    mom_next.mag[0]    = s1_mx[SUM_W-1] ? MAG_W'(-s1_mx) : MAG_W'(s1_mx);
    mom_next.mag[1]    = s1_my[SUM_W-1] ? MAG_W'(-s1_my) : MAG_W'(s1_my);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s1_valid;
    end
    if (en) begin
      mom <= mom_next;
    end
  end

endmodule

// ===== src/lbmc_vel_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbmc_vel_div: pipelined velocity divider
// Two lanes of restoring division, one quotient bit per stage, with clamp.
// ----------------------------------------------------------------------------
module lbmc_vel_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  lbmc_pkg::mom_t mom,
  output logic           out_valid,
  output lbmc_pkg::ctx_t ctx
);

  localparam int DW     = lbmc_pkg::DW;
  localparam int FB     = lbmc_pkg::FB;
  localparam int MAG_W  = lbmc_pkg::MAG_W;
  localparam int NB     = DW - 1;
  localparam int DVD_W  = MAG_W + FB;
  localparam int HEAD_W = DVD_W - (DW - 1);

  typedef struct packed {
    logic                 valid;
    lbmc_pkg::ctx_t       ctx;
    logic                 rho_pos;
    logic [1:0]           neg;
    logic [1:0]           ovf;
    logic [1:0][DW-2:0]   rem;
    logic [1:0][DW-2:0]   low;
    logic [1:0][DW-2:0]   quo;
  } dstage_t;

  dstage_t st     [NB+1];
  dstage_t st_next[NB+1];

  // Split the shifted dividend: the head is compared against rho for the
  // clamp, the low bits shift in one per stage.
  always_comb begin
    logic [DVD_W-1:0]  dvd;
    logic [HEAD_W-1:0] head;
    st_next[0].valid   = in_valid;
    st_next[0].ctx     = mom.ctx;
    st_next[0].rho_pos = mom.rho_pos;
    st_next[0].neg     = mom.neg;
    for (int l = 0; l < 2; l++) begin
      dvd  = {mom.mag[l], {FB{1'b0}}};
      head = dvd[DVD_W-1:DW-1];
      st_next[0].ovf[l] = head >= HEAD_W'(mom.ctx.rho[DW-2:0]);
      st_next[0].rem[l] = head[DW-2:0];
      st_next[0].low[l] = dvd[DW-2:0];
      st_next[0].quo[l] = '0;
    end
  end

  for (genvar j = 1; j <= NB; j++) begin : g_step
    always_comb begin
      logic [DW-1:0] t;
      logic [DW-1:0] dv;
      logic [DW-1:0] df;
      st_next[j] = st[j-1];
      dv = {1'b0, st[j-1].ctx.rho[DW-2:0]};
      for (int l = 0; l < 2; l++) begin
        t  = {st[j-1].rem[l], st[j-1].low[l][DW-2]};
        df = t - dv;
        if (t >= dv) begin
          st_next[j].rem[l] = df[DW-2:0];
        end else begin
          st_next[j].rem[l] = t[DW-2:0];
        end
        st_next[j].quo[l] = {st[j-1].quo[l][DW-3:0], t >= dv};
        st_next[j].low[l] = {st[j-1].low[l][DW-3:0], 1'b0};
      end
    end
  end

  for (genvar j = 0; j <= NB; j++) begin : g_reg
    always_ff @(posedge clk) begin
      if (rst) begin
        st[j] <= '0;
      end else if (en) begin
        st[j] <= st_next[j];
      end
    end
  end

  // Apply sign, clamp and the non-positive density case.
  lbmc_pkg::ctx_t ctx_next;

  always_comb begin
    logic [DW-1:0]   q;
    lbmc_pkg::sval_t vel [2];
    for (int l = 0; l < 2; l++) begin
      q = st[NB].ovf[l] ? (DW'(1) << (DW-1)) : {1'b0, st[NB].quo[l]};
      if (!st[NB].rho_pos) begin
        vel[l] = '0;
      end else if (st[NB].neg[l]) begin
        vel[l] = DW'(0) - q;
      end else if (st[NB].ovf[l]) begin
        vel[l] = lbmc_pkg::VAL_MAX;
      end else begin
        vel[l] = q;
      end
    end
    ctx_next    = st[NB].ctx;
    ctx_next.ux = vel[0];
    ctx_next.uy = vel[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= st[NB].valid;
    end
    if (en) begin
      ctx <= ctx_next;
    end
  end

endmodule

// ===== src/lbmc_equil.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbmc_equil: BGK equilibrium distributions
// Six stages: c.u, squares, polynomial, rho*poly, reciprocal /9, correction.
// ----------------------------------------------------------------------------
module lbmc_equil (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  lbmc_pkg::ctx_t     ctx_in,
  output logic               out_valid,
  output lbmc_pkg::ctx_t     ctx,
  output lbmc_pkg::dir_vec_t feq
);

  localparam int DW     = lbmc_pkg::DW;
  localparam int FB     = lbmc_pkg::FB;
  localparam int NDIR   = lbmc_pkg::NDIR;
  localparam int SQ_W   = lbmc_pkg::SQ_W;
  localparam int UU_W   = lbmc_pkg::UU_W;
  localparam int PS_W   = lbmc_pkg::PS_W;
  localparam int P_W    = lbmc_pkg::P_W;
  localparam int A_W    = lbmc_pkg::A_W;
  localparam int RSH    = lbmc_pkg::RECIP_SH;
  localparam int NST    = 5;
  localparam logic signed [PS_W-1:0] ONE = PS_W'(1) << FB;

  // Context and valid travel through the first five stages; the sixth is
  // the output register.
  logic           vq   [NST];
  lbmc_pkg::ctx_t cq   [NST];

  for (genvar s = 0; s < NST; s++) begin : g_ctx
    always_ff @(posedge clk) begin
      if (rst) begin
        vq[s] <= 1'b0;
      end else if (en) begin
        vq[s] <= (s == 0) ? in_valid : vq[(s == 0) ? 0 : s-1];
      end
      if (en) begin
        cq[s] <= (s == 0) ? ctx_in : cq[(s == 0) ? 0 : s-1];
      end
    end
  end

  // Stage 1: c.u per direction and the velocity squares.
  lbmc_pkg::dir_vec_t          e1_cu;
  logic signed [2*DW-1:0]      e1_ux2;
  logic signed [2*DW-1:0]      e1_uy2;
  lbmc_pkg::dir_vec_t          cu_c;

  always_comb begin
    logic signed [DW+1:0] xs;
    logic signed [DW+1:0] ys;
    for (int k = 0; k < NDIR; k++) begin
      xs = '0;
      ys = '0;
      if (lbmc_pkg::DIR_X[k] == 2'sd1) begin
        xs = (DW+2)'(ctx_in.ux);
      end else if (lbmc_pkg::DIR_X[k] == -2'sd1) begin
        xs = -(DW+2)'(ctx_in.ux);
      end
      if (lbmc_pkg::DIR_Y[k] == 2'sd1) begin
        ys = (DW+2)'(ctx_in.uy);
      end else if (lbmc_pkg::DIR_Y[k] == -2'sd1) begin
        ys = -(DW+2)'(ctx_in.uy);
      end
      cu_c[k] = lbmc_pkg::sat(64'(xs + ys));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_cu  <= cu_c;
      e1_ux2 <= ctx_in.ux * ctx_in.ux;
      e1_uy2 <= ctx_in.uy * ctx_in.uy;
    end
  end

  // Stage 2: (c.u)^2 and u.u, scaled down to Q format.
  lbmc_pkg::dir_vec_t        e2_cu;
  logic [NDIR-1:0][SQ_W-1:0] e2_sq;
  logic [UU_W-1:0]           e2_uu;

  always_ff @(posedge clk) begin
    logic signed [2*DW-1:0] p;
    logic [2*DW:0]          s;
    if (en) begin
      e2_cu <= e1_cu;
      for (int k = 0; k < NDIR; k++) begin
        p = e1_cu[k] * e1_cu[k];
        e2_sq[k] <= p[2*DW-1:FB];
      end
      s = (2*DW+1)'(unsigned'(e1_ux2)) + (2*DW+1)'(unsigned'(e1_uy2));
      e2_uu <= s[2*DW:FB];
    end
  end

  // Stage 3: 1 + 3cu + 4.5 cu^2 - 1.5 u.u, saturated.
  lbmc_pkg::dir_vec_t e3_poly;

  always_ff @(posedge clk) begin
    logic signed [PS_W-1:0] cu3;
    logic [PS_W-1:0]        sq9h;
    logic [PS_W-1:0]        uu3h;
    logic signed [PS_W-1:0] ps;
    if (en) begin
      uu3h = (PS_W'(e2_uu) * PS_W'(3)) >> 1;
      for (int k = 0; k < NDIR; k++) begin
        cu3  = PS_W'(e2_cu[k]) * PS_W'(3);
        sq9h = (PS_W'(e2_sq[k]) * PS_W'(9)) >> 1;
        ps   = ONE + cu3 + signed'(sq9h) - signed'(uu3h);
        e3_poly[k] <= lbmc_pkg::sat(64'(ps));
      end
    end
  end

  // Stage 4: rho * poly.
  logic signed [NDIR-1:0][2*DW-1:0] e4_prod;

  always_ff @(posedge clk) begin
    logic signed [2*DW-1:0] p;
    if (en) begin
      for (int k = 0; k < NDIR; k++) begin
        p = cq[2].rho * e3_poly[k];
        e4_prod[k] <= p;
      end
    end
  end

  // Stage 5: weight scaling as a magnitude, then multiply by 1/9.
  logic [NDIR-1:0][A_W-1:0] e5_a;
  logic [NDIR-1:0][A_W-1:0] e5_q0;
  logic [NDIR-1:0]          e5_neg;

  always_ff @(posedge clk) begin
    logic signed [P_W-1:0] pv;
    logic [P_W-1:0]        mg;
    logic [A_W-1:0]        a;
    logic [A_W+RSH-1:0]    m;
    if (en) begin
      for (int k = 0; k < NDIR; k++) begin
        pv = e4_prod[k][2*DW-1:FB];
        mg = pv[P_W-1] ? P_W'(-pv) : P_W'(pv);
        case (lbmc_pkg::DIR_WT[k])
          lbmc_pkg::WT_REST: a = {mg, 2'b00};
          lbmc_pkg::WT_AXIS: a = A_W'(mg);
          lbmc_pkg::WT_DIAG: a = A_W'(mg >> 2);
          default:           a = A_W'(mg);
        endcase
        m = (A_W+RSH)'(a) * (A_W+RSH)'(lbmc_pkg::RECIP9);
        e5_a[k]   <= a;
        e5_q0[k]  <= m[A_W+RSH-1:RSH];
        e5_neg[k] <= pv[P_W-1];
      end
    end
  end

  // Stage 6: one-step correction of the quotient, sign and saturate.
  always_ff @(posedge clk) begin
    logic [A_W-1:0]         r;
    logic [A_W-1:0]         q;
    logic signed [63:0]     qs;
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vq[NST-1];
    end
    if (en) begin
      ctx <= cq[NST-1];
      for (int k = 0; k < NDIR; k++) begin
        r  = e5_a[k] - A_W'(9) * e5_q0[k];
        q  = (r >= A_W'(9)) ? e5_q0[k] + A_W'(1) : e5_q0[k];
        qs = signed'(64'(q));
        feq[k] <= lbmc_pkg::sat(e5_neg[k] ? -qs : qs);
      end
    end
  end

endmodule

// ===== src/lbmc_relax.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbmc_relax: BGK relaxation and bounce-back
// Two stages: omega*(feq - f), then add, saturate and build the result beat.
// ----------------------------------------------------------------------------
module lbmc_relax (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  lbmc_pkg::ctx_t                ctx_in,
  input  lbmc_pkg::dir_vec_t            feq,
  input  logic [lbmc_pkg::OMEGA_W-1:0]  omega,
  output logic                          result_valid,
  output lbmc_pkg::result_beat_t        result
);

  localparam int DW   = lbmc_pkg::DW;
  localparam int NDIR = lbmc_pkg::NDIR;
  localparam int OW   = lbmc_pkg::OMEGA_W;
  localparam int OFB  = lbmc_pkg::OMEGA_FB;
  localparam int PR_W = OW + 1 + DW + 1;

  logic                             r1_valid;
  lbmc_pkg::ctx_t                   r1_ctx;
  logic signed [NDIR-1:0][PR_W-1:0] r1_prod;

  always_ff @(posedge clk) begin
    logic signed [DW:0]   d;
    logic signed [PR_W-1:0] p;
    if (rst) begin
      r1_valid <= 1'b0;
    end else if (en) begin
      r1_valid <= in_valid;
    end
    if (en) begin
      r1_ctx <= ctx_in;
      for (int k = 0; k < NDIR; k++) begin
        d = (DW+1)'(feq[k]) - (DW+1)'(ctx_in.f[k]);
        p = $signed({1'b0, omega}) * d;
        r1_prod[k] <= p;
      end
    end
  end

  lbmc_pkg::result_beat_t result_next;

  always_comb begin
    logic signed [PR_W-OFB-1:0] delta;
    lbmc_pkg::dir_vec_t         pa;
    for (int k = 0; k < NDIR; k++) begin
      delta = r1_prod[k][PR_W-1:OFB];
      if (r1_ctx.solid) begin
        pa[k] = r1_ctx.f[lbmc_pkg::DIR_OPP[k]];
      end else begin
        pa[k] = lbmc_pkg::sat(64'($signed(r1_ctx.f[k])) + 64'(delta));
      end
    end
    result_next.post_0  = pa[0];
    result_next.post_1  = pa[1];
    result_next.post_2  = pa[2];
    result_next.post_3  = pa[3];
    result_next.post_4  = pa[4];
    result_next.post_5  = pa[5];
    result_next.post_6  = pa[6];
    result_next.post_7  = pa[7];
    result_next.post_8  = pa[8];
    result_next.density = r1_ctx.solid ? '0 : r1_ctx.rho;
    result_next.vel_x   = r1_ctx.solid ? '0 : r1_ctx.ux;
    result_next.vel_y   = r1_ctx.solid ? '0 : r1_ctx.uy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= r1_valid;
    end
    if (en) begin
      result <= result_next;
    end
  end

endmodule

// ===== src/lbm_d2q9_node_collision_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbm_d2q9_node_collision_core: D2Q9 lattice Boltzmann BGK collision kernel
// Density, velocity, equilibrium and relaxation of one node per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Node channel (node_valid / node_stall / node): one beat carries the nine
//   distributions of a node and its solid flag. A beat is taken at a clock
//   edge with node_valid high and node_stall low.
//   Result channel (result_valid / result_stall / result): one beat per node,
//   in order, with the post-collision distributions and density/velocity.
//   omega_wr_en / omega_wr_data load the relaxation rate (Q1.16); write it
//   only while no node is in flight.
// Timing:
//   A node beat passes through two moment stages, a 25-stage divider (one
//   quotient bit per stage for the two velocity lanes), six equilibrium
//   stages and two relaxation stages. A new node enters every cycle unless
//   a held result stalls the pipeline, so throughput is one node per clock.
// Reset:
//   rst (synchronous) empties the pipeline and sets omega to 1.0.
// Stall:
//   When the result is held by result_stall, the whole pipeline freezes and
//   node_stall rises in the same cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module lbm_d2q9_node_collision_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          node_valid,
  output logic                          node_stall,
  input  lbmc_pkg::node_beat_t          node,
  output logic                          result_valid,
  input  logic                          result_stall,
  output lbmc_pkg::result_beat_t        result,
  input  logic                          omega_wr_en,
  input  logic [lbmc_pkg::OMEGA_W-1:0]  omega_wr_data
);

  // Relaxation rate register.
  logic [lbmc_pkg::OMEGA_W-1:0] omega;

  always_ff @(posedge clk) begin
    if (rst) begin
      omega <= lbmc_pkg::OMEGA_RESET;
    end else if (omega_wr_en) begin
      omega <= omega_wr_data;
    end
  end

  // Advance every stage together unless the result beat is held.
  logic hold;
  logic en;

  assign hold       = result_valid && result_stall;
  assign en         = !hold;
  assign node_stall = hold;

  // Moments: sums, then saturated density and momentum magnitudes.
  logic           mom_valid;
  lbmc_pkg::mom_t mom;

  lbmc_moments u_moments (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (node_valid),
    .node      (node),
    .out_valid (mom_valid),
    .mom       (mom)
  );

  // Velocity: momentum / density, bit-serial over the pipeline.
  logic           vel_valid;
  lbmc_pkg::ctx_t vel_ctx;

  lbmc_vel_div u_vel_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (mom_valid),
    .mom       (mom),
    .out_valid (vel_valid),
    .ctx       (vel_ctx)
  );

  // Equilibrium distributions for each direction.
  logic               eq_valid;
  lbmc_pkg::ctx_t     eq_ctx;
  lbmc_pkg::dir_vec_t feq;

  lbmc_equil u_equil (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vel_valid),
    .ctx_in    (vel_ctx),
    .out_valid (eq_valid),
    .ctx       (eq_ctx),
    .feq       (feq)
  );

  // Relax toward equilibrium, or bounce back on a solid node.
  lbmc_relax u_relax (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (eq_valid),
    .ctx_in       (eq_ctx),
    .feq          (feq),
    .omega        (omega),
    .result_valid (result_valid),
    .result       (result)
  );

  // An empty output register never blocks the node channel.
  a_no_stall_when_empty: assert property (
    @(posedge clk) disable iff (rst) !result_valid |-> !node_stall
  ) else $error("node channel stalled with no result pending");

  // Zero or negative density always reports zero velocity.
  a_zero_vel: assert property (
    @(posedge clk) disable iff (rst)
      result_valid && ($signed(result.density) <= 0) |->
        (result.vel_x == '0) && (result.vel_y == '0)
  ) else $error("nonzero velocity at non-positive density");

  // Reset restores omega to 1.0.
  a_omega_reset: assert property (
    @(posedge clk) $past(rst) |-> omega == lbmc_pkg::OMEGA_RESET
  ) else $error("omega not at its reset value after reset");

endmodule
